FILE: rtl/pbwr_pkg.sv
`default_nettype none

package pbwr_pkg;

	// Field and register widths
	localparam int BYTE_BITS      = 8;
	localparam int WIDTH_BITS     = 6;
	localparam int NUM_BITS       = 20;
	localparam int MAX_VALUE_BITS = 32;
	localparam int ADDR_BITS      = 4;
	localparam int DATA_BITS      = 32;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_IN_BITS    = 2'd0;
	localparam logic [1:0] REG_OUT_BITS   = 2'd1;
	localparam logic [1:0] REG_NUM_VALUES = 2'd2;

	localparam logic [WIDTH_BITS-1:0] RST_IN_BITS    = 6'd8;
	localparam logic [WIDTH_BITS-1:0] RST_OUT_BITS   = 6'd8;
	localparam logic [NUM_BITS-1:0]   RST_NUM_VALUES = 20'd1;

	typedef logic [WIDTH_BITS-1:0] width_t;
	typedef logic [WIDTH_BITS:0]   wsum_t;
	// bit position or bit count within a byte, 0..8
	typedef logic [3:0]            pos_t;

	localparam pos_t POS_END = 4'd8;

	typedef struct packed {
		width_t                in_bits;
		width_t                out_bits;
		logic [NUM_BITS-1:0]   num_values;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] data;   // input byte being worked on
		pos_t                 bpos;   // next input bit; POS_END = byte used up
		logic                 pend;   // value's input bits all seen, padding/close pending
		width_t               ivb;    // input bits of current value consumed
		width_t               ovb;    // output bits of current value placed
		logic [BYTE_BITS-1:0] acc;    // output byte being assembled
		pos_t                 fill;   // bits held in acc, 0..8
	} state_t;

	typedef struct packed {
		logic                 active;
		logic                 emit;
		logic [BYTE_BITS-1:0] emit_byte;
		logic                 emit_last;
	} event_t;

	// 0 acts as 1, anything above the maximum as the maximum
	function automatic width_t eff_width(input width_t w);
		if (w == '0)
			return width_t'(1);
		if (w > width_t'(MAX_VALUE_BITS))
			return width_t'(MAX_VALUE_BITS);
		return w;
	endfunction

	function automatic pos_t min_pos(input pos_t a, input pos_t b);
		return (a < b) ? a : b;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pbwr_regs.sv
`default_nettype none

module pbwr_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pbwr_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [pbwr_pkg::DATA_BITS-1:0]   pwdata,
	output logic [pbwr_pkg::DATA_BITS-1:0]   prdata,
	output logic                             pready,
	output pbwr_pkg::cfg_t                   cfg
);

	logic [1:0]      idx;
	logic            wr_en;
	pbwr_pkg::cfg_t  cfg_q;

	assign idx    = paddr[pbwr_pkg::ADDR_BITS-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_bits    <= pbwr_pkg::RST_IN_BITS;
			cfg_q.out_bits   <= pbwr_pkg::RST_OUT_BITS;
			cfg_q.num_values <= pbwr_pkg::RST_NUM_VALUES;
		end else if (wr_en) begin
			unique case (idx)
				pbwr_pkg::REG_IN_BITS: begin
					cfg_q.in_bits <= pwdata[pbwr_pkg::WIDTH_BITS-1:0];
				end
				pbwr_pkg::REG_OUT_BITS: begin
					cfg_q.out_bits <= pwdata[pbwr_pkg::WIDTH_BITS-1:0];
				end
				pbwr_pkg::REG_NUM_VALUES: begin
					cfg_q.num_values <= pwdata[pbwr_pkg::NUM_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pbwr_pkg::REG_IN_BITS:    prdata = pbwr_pkg::DATA_BITS'(cfg_q.in_bits);
			pbwr_pkg::REG_OUT_BITS:   prdata = pbwr_pkg::DATA_BITS'(cfg_q.out_bits);
			pbwr_pkg::REG_NUM_VALUES: prdata = pbwr_pkg::DATA_BITS'(cfg_q.num_values);
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/pbwr_step.sv
`default_nettype none

// One engine step: moves a run of up to eight bits (copy, drop or zero pad)
// into the output byte, flushes a full byte first, and closes values and
// tensors. At most one output byte per step.
module pbwr_step #(
	parameter int COUNT_BITS = 20
) (
	input  pbwr_pkg::cfg_t          cfg,
	input  pbwr_pkg::state_t        cur,
	input  logic [COUNT_BITS-1:0]   vd,
	output pbwr_pkg::state_t        nxt,
	output logic [COUNT_BITS-1:0]   vd_next,
	output pbwr_pkg::event_t        ev
);

	localparam int CW = (COUNT_BITS > pbwr_pkg::NUM_BITS) ? COUNT_BITS : pbwr_pkg::NUM_BITS;
	localparam logic [CW-1:0] CNT_MASK = {CW{1'b1}} >> (CW - COUNT_BITS);

	pbwr_pkg::width_t  ib, ob, need_in, out_left;
	pbwr_pkg::pos_t    avail, room, k_in, cap, pk, consumed, fill_base, fill_n, bpos_n;
	pbwr_pkg::wsum_t   ivb_sum, ovb_sum;
	logic [pbwr_pkg::BYTE_BITS-1:0] acc_base, src, mask, placed, acc_n;
	logic              active, placing, flush, done_in, ob_full;
	logic              value_end, t_end, defer;
	logic [COUNT_BITS-1:0] vd_inc;
	logic [CW-1:0]     nv_m, nv_eff;

	assign ib = pbwr_pkg::eff_width(cfg.in_bits);
	assign ob = pbwr_pkg::eff_width(cfg.out_bits);

	assign active  = cur.pend || (cur.bpos != pbwr_pkg::POS_END);
	assign placing = cur.ovb < ob;
	// a held full byte goes out only when another bit is to be placed
	assign flush   = active && placing && (cur.fill == pbwr_pkg::POS_END);

	assign fill_base = flush ? '0 : cur.fill;
	assign acc_base  = flush ? '0 : cur.acc;
	assign room      = pbwr_pkg::POS_END - fill_base;

	// at least one input bit per value even if the width shrank below the count
	assign need_in  = (cur.ivb < ib) ? (ib - cur.ivb) : pbwr_pkg::width_t'(1);
	assign avail    = pbwr_pkg::POS_END - cur.bpos;
	assign k_in     = (need_in < pbwr_pkg::width_t'(avail)) ? need_in[3:0] : avail;
	assign out_left = ob - cur.ovb;

	assign cap      = cur.pend ? room : pbwr_pkg::min_pos(k_in, room);
	assign pk       = !placing ? '0 :
	                  (out_left < pbwr_pkg::width_t'(cap)) ? out_left[3:0] : cap;
	assign consumed = cur.pend ? '0 : (placing ? pk : k_in);

	assign src    = cur.pend ? '0 : (cur.data >> cur.bpos);
	assign mask   = ~(8'hFF << pk);
	assign placed = (src & mask) << fill_base;
	assign acc_n  = acc_base | placed;
	assign fill_n = fill_base + pk;
	assign bpos_n = cur.bpos + consumed;

	assign ivb_sum = pbwr_pkg::wsum_t'(cur.ivb) + pbwr_pkg::wsum_t'(consumed);
	assign ovb_sum = pbwr_pkg::wsum_t'(cur.ovb) + pbwr_pkg::wsum_t'(pk);
	assign done_in = cur.pend || (ivb_sum >= pbwr_pkg::wsum_t'(ib));
	assign ob_full = ovb_sum >= pbwr_pkg::wsum_t'(ob);

	assign value_end = active && done_in && ob_full;
	assign vd_inc    = vd + COUNT_BITS'(1);
	assign nv_m      = CW'(cfg.num_values) & CNT_MASK;
	assign nv_eff    = (nv_m == '0) ? CW'(1) : nv_m;
	assign t_end     = value_end && (CW'(vd_inc) >= nv_eff);
	// flush and closing byte cannot share a step: close on the next one
	assign defer     = t_end && flush;

	always_comb begin
		nxt       = cur;
		vd_next   = vd;
		ev        = '0;
		ev.active = active;
		if (active) begin
			nxt.acc  = acc_n;
			nxt.fill = fill_n;
			nxt.bpos = bpos_n;
			nxt.ivb  = ivb_sum[pbwr_pkg::WIDTH_BITS-1:0];
			nxt.ovb  = ovb_sum[pbwr_pkg::WIDTH_BITS-1:0];
			nxt.pend = done_in;
			if (value_end && !defer) begin
				nxt.ivb  = '0;
				nxt.ovb  = '0;
				nxt.pend = 1'b0;
				if (t_end) begin
					nxt.acc  = '0;
					nxt.fill = '0;
					nxt.bpos = pbwr_pkg::POS_END;  // rest of the byte is dropped
					vd_next  = '0;
				end else begin
					vd_next  = vd_inc;
				end
			end
			ev.emit      = flush || (t_end && !defer);
			ev.emit_byte = flush ? cur.acc : acc_n;
			ev.emit_last = !flush;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/packed_bit_width_repacker.sv
`default_nettype none

// Channel   Dir  Handshake                   Payload
// config    in   psel/penable/pwrite, pready paddr, pwdata, prdata (APB, regs at 0x0/0x4/0x8)
// input     in   in_valid / in_stall         in_byte
// output    out  out_valid / out_stall       out_byte, last
//
// A transfer happens on a rising edge with valid high and stall low.
// An input byte is taken into the working register and drained there by one
// engine step per cycle unless a stalled output holds the engine; each step
// moves a run of bits (copy, drop or pad) and can hand one byte to the output
// register. A step ends at a value boundary, at the end of a pad run, at the
// end of the input byte or when the output byte fills. Closing a tensor in
// the step that flushes a full byte is put off to a step of its own. The next
// byte is taken in the cycle the current one finishes.
// Reset clears the engine and the registers to in_bits=8, out_bits=8,
// num_values=1. A stalled output holds the engine only when a step has a
// byte to hand over.
module packed_bit_width_repacker #(
	parameter int COUNT_BITS = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pbwr_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [pbwr_pkg::DATA_BITS-1:0]   pwdata,
	output logic [pbwr_pkg::DATA_BITS-1:0]   prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [pbwr_pkg::BYTE_BITS-1:0]   in_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [pbwr_pkg::BYTE_BITS-1:0]   out_byte,
	output logic                             last
);

	pbwr_pkg::cfg_t    cfg;
	pbwr_pkg::state_t  st_q, st_next, st_load;
	pbwr_pkg::event_t  ev;
	logic [COUNT_BITS-1:0] vd_q, vd_next;
	logic              out_valid_q, last_q;
	logic [pbwr_pkg::BYTE_BITS-1:0] out_byte_q;
	logic              out_free, step_en, in_take;

	pbwr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pbwr_step #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.cfg     (cfg),
		.cur     (st_q),
		.vd      (vd_q),
		.nxt     (st_next),
		.vd_next (vd_next),
		.ev      (ev)
	);

	// output slot is free if empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign step_en  = !ev.emit || out_free;

	// take a new byte once the engine is empty or empties on this step
	assign in_stall = ev.active &&
	                  !(step_en && (st_next.bpos == pbwr_pkg::POS_END) && !st_next.pend);
	assign in_take  = in_valid && !in_stall;

	// a new byte lands in the working register in place of the used-up one
	always_comb begin
		st_load = st_next;
		if (in_take) begin
			st_load.data = in_byte;
			st_load.bpos = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.data <= '0;
			st_q.bpos <= pbwr_pkg::POS_END;
			st_q.pend <= 1'b0;
			st_q.ivb  <= '0;
			st_q.ovb  <= '0;
			st_q.acc  <= '0;
			st_q.fill <= '0;
			vd_q      <= '0;
		end else if (step_en) begin
			st_q <= st_load;
			vd_q <= vd_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= ev.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && ev.emit) begin
			out_byte_q <= ev.emit_byte;
			last_q     <= ev.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	// engine bookkeeping
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fill <= pbwr_pkg::POS_END && st_q.bpos <= pbwr_pkg::POS_END)
		else $error("engine fill or bit position out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !st_q.pend && st_q.bpos == '0)
		else $error("byte taken while the previous one was still in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_free && ev.emit && ev.emit_last |=> st_q.fill == '0 && vd_q == '0)
		else $error("tensor close left state behind");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && ev.emit |=> st_q == $past(st_q))
		else $error("engine moved while its byte could not be handed over");

endmodule

`default_nettype wire

FILE: sim/pbwr_checker.sv
`timescale 1ns / 100ps

// Watches the register port and both streams, predicts the output bytes and
// compares every output transfer with the oldest predicted byte.
module pbwr_checker #(
	parameter int COUNT_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [pbwr_pkg::ADDR_BITS-1:0] paddr,
	input  logic [pbwr_pkg::DATA_BITS-1:0] pwdata,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [pbwr_pkg::BYTE_BITS-1:0] in_byte,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [pbwr_pkg::BYTE_BITS-1:0] out_byte,
	input  logic                           last,
	output int unsigned                    pending,
	output int unsigned                    errors
);

	typedef struct packed {
		logic [pbwr_pkg::BYTE_BITS-1:0] data;
		logic                           last;
	} out_rec_t;

	out_rec_t byte_q[$];

	// register copies
	pbwr_pkg::width_t              cfg_in;
	pbwr_pkg::width_t              cfg_out;
	logic [pbwr_pkg::NUM_BITS-1:0] cfg_num;

	// repacking position
	pbwr_pkg::width_t               in_pos;
	pbwr_pkg::width_t               out_pos;
	logic [pbwr_pkg::BYTE_BITS-1:0] acc;
	logic [3:0]                     acc_fill;
	logic [COUNT_BITS-1:0]          done_cnt;
	int unsigned                    err_cnt;

	function automatic int clamp_width(input pbwr_pkg::width_t w);
		if (w == '0)
			return 1;
		if (int'(w) > pbwr_pkg::MAX_VALUE_BITS)
			return pbwr_pkg::MAX_VALUE_BITS;
		return int'(w);
	endfunction

	// a full byte stays held until one more bit shows up
	task automatic put_bit(input logic b_in);
		if (acc_fill >= 4'd8) begin
			byte_q.push_back({acc, 1'b0});
			acc      = '0;
			acc_fill = '0;
		end
		acc[acc_fill[2:0]] = b_in;
		acc_fill++;
	endtask

	task automatic repack_byte(input logic [pbwr_pkg::BYTE_BITS-1:0] din);
		int                    ib;
		int                    ob;
		logic [COUNT_BITS-1:0] nv;
		ib = clamp_width(cfg_in);
		ob = clamp_width(cfg_out);
		nv = COUNT_BITS'(cfg_num);
		if (nv == '0)
			nv = COUNT_BITS'(1);
		for (int k = 0; k < pbwr_pkg::BYTE_BITS; k++) begin
			if (int'(out_pos) < ob) begin
				put_bit(din[k]);
				out_pos++;
			end
			in_pos++;
			if (int'(in_pos) >= ib) begin
				while (int'(out_pos) < ob) begin
					put_bit(1'b0);
					out_pos++;
				end
				in_pos  = '0;
				out_pos = '0;
				done_cnt++;
				if (done_cnt >= nv) begin
					// tensor closes: flush, rest of this byte is dropped
					byte_q.push_back({acc, 1'b1});
					acc      = '0;
					acc_fill = '0;
					done_cnt = '0;
					break;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_rec_t want;
		if (!arst_n) begin
			cfg_in   = pbwr_pkg::RST_IN_BITS;
			cfg_out  = pbwr_pkg::RST_OUT_BITS;
			cfg_num  = pbwr_pkg::RST_NUM_VALUES;
			in_pos   = '0;
			out_pos  = '0;
			acc      = '0;
			acc_fill = '0;
			done_cnt = '0;
			err_cnt  = 0;
			byte_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					pbwr_pkg::REG_IN_BITS:
						cfg_in  = pwdata[pbwr_pkg::WIDTH_BITS-1:0];
					pbwr_pkg::REG_OUT_BITS:
						cfg_out = pwdata[pbwr_pkg::WIDTH_BITS-1:0];
					pbwr_pkg::REG_NUM_VALUES:
						cfg_num = pwdata[pbwr_pkg::NUM_BITS-1:0];
					default: ;
				endcase
			end
			// check the output first so a byte taken at this edge cannot hide a stray one
			if (out_valid && !out_stall) begin
				if (byte_q.size() == 0) begin
					err_cnt++;
					$display("%0t: stray output transfer, expected none, actual %02h last %0b",
						$time, out_byte, last);
				end else begin
					want = byte_q.pop_front();
					if (out_byte !== want.data) begin
						err_cnt++;
						$display("%0t: out_byte mismatch, expected %02h, actual %02h",
							$time, want.data, out_byte);
					end
					if (last !== want.last) begin
						err_cnt++;
						$display("%0t: last mismatch, expected %0b, actual %0b",
							$time, want.last, last);
					end
				end
			end
			if (in_valid && !in_stall)
				repack_byte(in_byte);
		end
		pending <= byte_q.size();
		errors  <= err_cnt;
	end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the bit width repacker. The checker beside the
// block does all prediction and comparison; this module only drives.
module tb_top;

	localparam int CNT_BITS   = 20;
	localparam int IDLE_GAP   = 100;   // cycles for the engine to finish a byte
	localparam int HOLD_LEN   = 400;   // receiver hold-off, long enough to back up the input
	localparam int END_LIMIT  = 50000;
	localparam int FREE_START = 1000;  // receiver takes every byte in this window
	localparam int FREE_END   = 1600;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [pbwr_pkg::ADDR_BITS-1:0] paddr;
	logic [pbwr_pkg::DATA_BITS-1:0] pwdata;
	logic [pbwr_pkg::DATA_BITS-1:0] prdata;
	logic                           pready;
	logic                           in_valid;
	logic                           in_stall;
	logic [pbwr_pkg::BYTE_BITS-1:0] in_byte;
	logic                           out_valid;
	logic                           out_stall;
	logic [pbwr_pkg::BYTE_BITS-1:0] out_byte;
	logic                           last;

	int unsigned pending;
	int unsigned errors;
	int          sent;      // input transfers so far
	logic        hold_go;   // asks the receiver for its long hold-off

	packed_bit_width_repacker #(
		.COUNT_BITS(CNT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.last     (last)
	);

	pbwr_checker #(
		.COUNT_BITS(CNT_BITS)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.last     (last),
		.pending  (pending),
		.errors   (errors)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop in case the block locks up
	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	// APB write: setup phase, access phase, then an idle phase with psel low so that
	// back-to-back writes never lower and raise psel in the same step.
	task automatic write_reg(input logic [1:0] idx,
		input logic [pbwr_pkg::DATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= pbwr_pkg::ADDR_BITS'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Noise in the unused upper bits of pwdata; the block must ignore it
	task automatic set_regs(input int ib, input int ob, input int nv, input bit noisy);
		logic [pbwr_pkg::DATA_BITS-1:0] junk;
		junk = noisy ? $urandom : '0;
		write_reg(pbwr_pkg::REG_IN_BITS, (junk & ~32'h3f) | pbwr_pkg::DATA_BITS'(ib));
		write_reg(pbwr_pkg::REG_OUT_BITS, (junk & ~32'h3f) | pbwr_pkg::DATA_BITS'(ob));
		write_reg(pbwr_pkg::REG_NUM_VALUES,
			(junk & ~32'hfffff) | pbwr_pkg::DATA_BITS'(nv));
	endtask

	// One input transfer. Gaps of random length go in front of the byte,
	// except during a stretch of transfers where the sender runs flat out.
	task automatic send_byte(input logic [pbwr_pkg::BYTE_BITS-1:0] b);
		if (!(sent >= 70 && sent < 95) && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 26);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Registers change only when the block is idle: every predicted byte
	// out, then enough cycles for a byte that produces nothing to drain.
	task automatic settle();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	// Receiver: random stalls, one long hold-off on request, and a stretch
	// of cycles with no stall at all.
	initial begin
		int cyc;
		int hold_left;
		bit held;
		out_stall = 1'b0;
		cyc       = 0;
		hold_left = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_go && !held) begin
				held      = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (cyc >= FREE_START && cyc < FREE_END) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 26);
			end
		end
	end

	initial begin
		int rand_items;
		int phase;
		int ib;
		int ob;
		int nv;
		int ib_e;
		int ob_e;
		int nv_e;
		int n_bytes;
		int waited;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		in_byte    = '0;
		hold_go    = 1'b0;
		sent       = 0;
		rand_items = 0;
		phase      = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset widths 8/8, one value per tensor: every byte comes back with last
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'ha5);

		// 1-bit values widened to bytes: seven plain bytes then the closing one
		settle();
		set_regs(1, 8, 8, 1'b0);
		send_byte(8'hff);
		send_byte(8'h00);

		// 32-bit values narrowed to a single bit each
		settle();
		set_regs(32, 1, 2, 1'b0);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'hfe);
		send_byte(8'hff);
		send_byte(8'hff);
		send_byte(8'h7f);

		// Zero width acts as one, oversize as the maximum, zero count as one;
		// the rest of the byte after the single value is thrown away
		settle();
		set_regs(0, 63, 0, 1'b0);
		send_byte(8'h55);

		// Tensor ends two bits short of the byte end, the leftover is discarded
		settle();
		set_regs(3, 5, 2, 1'b0);
		send_byte(8'hc7);

		// Huge count, then the count is lowered mid-tensor: the next value closes it
		settle();
		set_regs(5, 3, 20'hfffff, 1'b0);
		send_byte(8'haa);
		send_byte(8'h33);
		send_byte(8'hcc);
		settle();
		write_reg(pbwr_pkg::REG_NUM_VALUES, 32'd1);
		send_byte(8'h0f);
		send_byte(8'hf0);

		// Random phases. Most use legal widths and short tensors so that many
		// tensors close; some hit the zero/oversize codes or never close.
		while (rand_items < 80) begin
			case ($urandom_range(9))
				0:       ib = 0;
				1:       ib = $urandom_range(33, 63);
				default: ib = $urandom_range(1, 32);
			endcase
			case ($urandom_range(9))
				0:       ob = 0;
				1:       ob = $urandom_range(33, 63);
				default: ob = $urandom_range(1, 32);
			endcase
			case ($urandom_range(11))
				0:       nv = 0;
				1:       nv = $urandom_range(20'h80000, 20'hfffff);
				2:       nv = $urandom_range(7, 40);
				default: nv = $urandom_range(1, 6);
			endcase
			ib_e = (ib == 0) ? 1 :
				((ib > pbwr_pkg::MAX_VALUE_BITS) ? pbwr_pkg::MAX_VALUE_BITS : ib);
			ob_e = (ob == 0) ? 1 :
				((ob > pbwr_pkg::MAX_VALUE_BITS) ? pbwr_pkg::MAX_VALUE_BITS : ob);
			nv_e = (nv == 0) ? 1 : nv;
			if (nv_e > 40)
				n_bytes = $urandom_range(2, 8);
			else
				n_bytes = ((nv_e * ib_e + 7) / 8) * $urandom_range(1, 2)
					+ (($urandom_range(3) == 0) ? $urandom_range(0, 3) : 0);
			if (n_bytes > 30)
				n_bytes = 30;
			settle();
			set_regs(ib, ob, nv, $urandom_range(3) == 0);
			// One phase keeps offering bytes while the receiver holds off
			if (phase == 2) begin
				hold_go <= 1'b1;
				if (n_bytes < 30)
					n_bytes = 30;
			end
			for (int k = 0; k < n_bytes; k++) begin
				send_byte(pbwr_pkg::BYTE_BITS'($urandom));
				rand_items++;
			end
			phase++;
		end

		in_valid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < END_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (IDLE_GAP) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
